[rtl/core/itf_pkg.sv]
`timescale 1ns / 1ps

package itf_pkg;

	localparam int MAX_DIGITS = 16;
	localparam int MAX_WIDTH  = 63;

	localparam int VAL_W   = 32;
	localparam int KIND_W  = 3;
	localparam int PAD_W   = 2;
	localparam int WID_W   = 6;
	localparam int CHAR_W  = 8;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 8;

	localparam int LEN_W  = $clog2(MAX_DIGITS + 2);
	localparam int BUF_N  = MAX_DIGITS + 1;
	localparam int PC_W   = 3;

	localparam logic [KIND_W-1:0] KIND_BIN  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_OCT  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SDEC = 3'd2;
	localparam logic [KIND_W-1:0] KIND_UDEC = 3'd3;
	localparam logic [KIND_W-1:0] KIND_HEXL = 3'd4;
	localparam logic [KIND_W-1:0] KIND_HEXU = 3'd5;

	localparam logic [PAD_W-1:0] PAD_RSPACE = 2'd0;
	localparam logic [PAD_W-1:0] PAD_RZERO  = 2'd1;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;

	// micro-operations
	localparam logic [2:0] OP_LOAD = 3'd0;
	localparam logic [2:0] OP_DIV  = 3'd1;
	localparam logic [2:0] OP_DIG  = 3'd2;
	localparam logic [2:0] OP_SIGN = 3'd3;
	localparam logic [2:0] OP_LPAD = 3'd4;
	localparam logic [2:0] OP_DIGS = 3'd5;
	localparam logic [2:0] OP_RPAD = 3'd6;
	localparam logic [2:0] OP_NOP  = 3'd7;

	// jump conditions
	localparam logic [2:0] C_NEVER    = 3'd0;
	localparam logic [2:0] C_NO_INPUT = 3'd1;
	localparam logic [2:0] C_MORE     = 3'd2;
	localparam logic [2:0] C_ACTIVE   = 3'd3;
	localparam logic [2:0] C_ALWAYS   = 3'd4;

	typedef struct packed {
		logic [2:0]      op;
		logic [2:0]      cond;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic       dec;
		logic [2:0] shamt;
		logic       upper;
	} radix_t;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			3'd0:    w = '{op: OP_LOAD, cond: C_NO_INPUT, target: 3'd0};
			3'd1:    w = '{op: OP_DIV,  cond: C_NEVER,    target: 3'd0};
			3'd2:    w = '{op: OP_DIG,  cond: C_MORE,     target: 3'd1};
			3'd3:    w = '{op: OP_SIGN, cond: C_NEVER,    target: 3'd0};
			3'd4:    w = '{op: OP_LPAD, cond: C_ACTIVE,   target: 3'd4};
			3'd5:    w = '{op: OP_DIGS, cond: C_ACTIVE,   target: 3'd5};
			3'd6:    w = '{op: OP_RPAD, cond: C_ACTIVE,   target: 3'd6};
			default: w = '{op: OP_NOP,  cond: C_ALWAYS,   target: 3'd0};
		endcase
		return w;
	endfunction

endpackage

[rtl/core/integer_to_text_formatter.sv]
`timescale 1ns / 1ps
// the first character is registered after the digit loop and the sign step, from the left
// padding step with left padding, else from the digit output step (no stall)
// one item at a time, N characters out, one character per cycle while the output is not stalled
// item time is set by the two-step digit loop (divide, then digit write) and the output register
// a new item is taken while the last character of the previous one waits in the output register
// arst_n clears the step counter and the output valid; data registers are not reset

module integer_to_text_formatter
	import itf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_DATA_W-1:0]  s_axis_tdata,   // value, pad_mode, min_width
	input  logic [KIND_W-1:0]    s_axis_tuser,   // conversion_kind
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_DATA_W-1:0]  m_axis_tdata,   // text_char
	output logic                 m_axis_tlast
);

	logic [VAL_W-1:0]  value;
	logic [KIND_W-1:0] conversion_kind;
	logic [PAD_W-1:0]  pad_mode;
	logic [WID_W-1:0]  min_width;

	assign value           = s_axis_tdata[31:0];
	assign conversion_kind = s_axis_tuser;
	assign pad_mode        = s_axis_tdata[33:32];
	assign min_width       = s_axis_tdata[39:34];

	logic [PC_W-1:0]   pc_q;
	logic [VAL_W-1:0]  v_q;
	logic [VAL_W-1:0]  q_q;
	logic              neg_q;
	radix_t            cfg_q;
	logic              left_q;
	logic [CHAR_W-1:0] padch_q;
	logic [WID_W-1:0]  w_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  i_q;
	logic [WID_W-1:0]  j_q;
	logic [CHAR_W-1:0] sbuf_q [BUF_N];
	logic              ovalid_q;
	logic [CHAR_W-1:0] ochar_q;
	logic              olast_q;

	uword_t            uw;
	logic              neg_in;
	radix_t            cfg_in;
	logic [VAL_W-1:0]  quot;
	logic [CHAR_W-1:0] dchar;
	logic              more;
	logic              act;
	logic              cond_true;
	logic              out_free;
	logic              emit;
	logic [CHAR_W-1:0] echar;
	logic              elast;
	logic [LEN_W-1:0]  len_sign;

	assign uw = ucode(pc_q);

	itf_digit u_digit (
		.cfg     (cfg_q),
		.value   (v_q),
		.quot_in (q_q),
		.quot    (quot),
		.dchar   (dchar)
	);

	assign neg_in = (conversion_kind == KIND_SDEC) && value[VAL_W-1];

	always_comb begin
		cfg_in = '{dec: 1'b1, shamt: 3'd0, upper: 1'b1};
		unique case (conversion_kind)
			KIND_BIN:            cfg_in = '{dec: 1'b0, shamt: 3'd1, upper: 1'b1};
			KIND_OCT:            cfg_in = '{dec: 1'b0, shamt: 3'd3, upper: 1'b1};
			KIND_HEXL:           cfg_in = '{dec: 1'b0, shamt: 3'd4, upper: 1'b0};
			KIND_HEXU:           cfg_in = '{dec: 1'b0, shamt: 3'd4, upper: 1'b1};
			default:             cfg_in = '{dec: 1'b1, shamt: 3'd0, upper: 1'b1};
		endcase
	end

	assign more     = (q_q != '0) && ((len_q + LEN_W'(1)) < LEN_W'(MAX_DIGITS));
	assign len_sign = len_q + LEN_W'(neg_q);
	assign out_free = !ovalid_q || m_axis_tready;

	always_comb begin
		act   = 1'b0;
		echar = CH_SPACE;
		elast = 1'b0;
		unique case (uw.op)
			OP_LPAD: begin
				act   = !left_q && (j_q < w_q);
				echar = padch_q;
			end
			OP_DIGS: begin
				act   = (i_q != '0);
				echar = sbuf_q[i_q - LEN_W'(1)];
				elast = (i_q == LEN_W'(1)) && !(j_q < w_q);
			end
			OP_RPAD: begin
				act   = (j_q < w_q);
				elast = (j_q == w_q - WID_W'(1));
			end
			default: begin
				act = 1'b0;
			end
		endcase
	end

	assign emit = (uw.op inside {OP_LPAD, OP_DIGS, OP_RPAD}) && act && out_free;

	always_comb begin
		unique case (uw.cond)
			C_NEVER:    cond_true = 1'b0;
			C_NO_INPUT: cond_true = !s_axis_tvalid;
			C_MORE:     cond_true = more;
			C_ACTIVE:   cond_true = act;
			C_ALWAYS:   cond_true = 1'b1;
			default:    cond_true = 1'b0;
		endcase
	end

	assign s_axis_tready = (uw.op == OP_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else begin
			pc_q <= cond_true ? uw.target : pc_q + PC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (uw.op) inside
			OP_LOAD: begin
				if (s_axis_tvalid) begin
					v_q     <= neg_in ? (VAL_W'(0) - value) : value;
					neg_q   <= neg_in;
					cfg_q   <= cfg_in;
					left_q  <= pad_mode[1];
					padch_q <= (pad_mode == PAD_RZERO) ? CH_ZERO : CH_SPACE;
					w_q     <= (min_width > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : min_width;
					len_q   <= '0;
				end
			end
			OP_DIV: begin
				q_q <= quot;
			end
			OP_DIG: begin
				sbuf_q[len_q] <= dchar;
				v_q           <= q_q;
				len_q         <= len_q + LEN_W'(1);
			end
			OP_SIGN: begin
				if (neg_q) begin
					sbuf_q[len_q] <= CH_MINUS;
				end
				len_q <= len_sign;
				i_q   <= len_sign;
				j_q   <= WID_W'(len_sign);
			end
			OP_LPAD, OP_RPAD: begin
				if (emit) begin
					j_q <= j_q + WID_W'(1);
				end
			end
			OP_DIGS: begin
				if (emit) begin
					i_q <= i_q - LEN_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit) begin
			ovalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ochar_q <= echar;
			olast_q <= elast;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = ochar_q;
	assign m_axis_tlast  = olast_q;

endmodule

[rtl/core/itf_digit.sv]
`timescale 1ns / 1ps

module itf_digit
	import itf_pkg::*;
(
	input  radix_t              cfg,
	input  logic [VAL_W-1:0]    value,
	input  logic [VAL_W-1:0]    quot_in,
	output logic [VAL_W-1:0]    quot,
	output logic [CHAR_W-1:0]   dchar
);

	logic [2*VAL_W-1:0] prod;
	logic [VAL_W-1:0]   q_dec;
	logic [VAL_W-1:0]   q_pow;
	logic [VAL_W-1:0]   tenq;
	logic [VAL_W-1:0]   diff;
	logic [3:0]         mask;
	logic [3:0]         dg;
	logic [CHAR_W-1:0]  letter;

	// divide by ten through the reciprocal
	assign prod  = {{VAL_W{1'b0}}, value} * 64'h0000_0000_CCCC_CCCD;
	assign q_dec = {3'b000, prod[63:35]};
	assign q_pow = value >> cfg.shamt;
	assign quot  = cfg.dec ? q_dec : q_pow;

	// remainder against the registered quotient
	assign tenq = {quot_in[VAL_W-4:0], 3'b000} + {quot_in[VAL_W-2:0], 1'b0};
	assign diff = value - tenq;
	assign mask = 4'((5'd1 << cfg.shamt) - 5'd1);
	assign dg   = cfg.dec ? diff[3:0] : (value[3:0] & mask);

	assign letter = cfg.upper ? CH_UA : CH_LA;
	assign dchar  = (dg > 4'd9) ? (letter + {4'b0000, dg - 4'd10}) : (CH_ZERO + {4'b0000, dg});

endmodule

[rtl/core/itf_checker.sv]
`timescale 1ns / 1ps

module itf_checker
	import itf_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [S_DATA_W-1:0]  s_axis_tdata,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_DATA_W-1:0]  m_axis_tdata,
	input logic                 m_axis_tlast
);

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");

	// a new item only once the previous run is down to its last character
	a_ready_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
		else $error("input ready in the middle of a run");

	// only digits, letters a-f and A-F, space and minus come out
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) ||
			(m_axis_tdata >= 8'h41 && m_axis_tdata <= 8'h46) ||
			(m_axis_tdata >= 8'h61 && m_axis_tdata <= 8'h66) ||
			m_axis_tdata == 8'h20 || m_axis_tdata == 8'h2D)
		else $error("character out of set");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled output transaction changed");

endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import itf_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;
	localparam logic [PAD_W-1:0]  PAD_LEFT     = 2'd2;
	localparam logic [PAD_W-1:0]  PAD_LEFT_ALT = 2'd3;

	localparam int GAP_MAX     = 18;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 120;
	localparam int RAND_ITEMS  = 220;

	typedef struct packed {
		logic [WID_W-1:0]  width;
		logic [PAD_W-1:0]  pad;
		logic [KIND_W-1:0] kind;
		logic [VAL_W-1:0]  value;
	} fmt_req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_beat_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;   // value, pad_mode, min_width
	logic [KIND_W-1:0]   s_axis_tuser = '0;   // conversion_kind
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;        // text_char
	logic                m_axis_tlast;

	text_beat_t pending_chars[$];
	int         errors = 0;
	int         items_sent = 0;
	int         chars_checked = 0;
	int         quiet_cycles = 0;
	int         rx_wait = 0;
	int         rx_gap;
	bit         tx_idle_en = 1'b0;
	bit         rx_idle_en = 1'b0;

	integer_to_text_formatter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic format_number_text(input fmt_req_t r);
		logic [CHAR_W-1:0] digs [BUF_N];
		logic [CHAR_W-1:0] line [$];
		logic [CHAR_W-1:0] pad_ch;
		logic [CHAR_W-1:0] letter;
		int unsigned       mag;
		int unsigned       radix;
		int unsigned       dg;
		int unsigned       len;
		int unsigned       j;
		int unsigned       w;
		logic              neg;
		logic              left;
		text_beat_t        beat;
		case (r.kind) inside
			KIND_BIN: radix = 2;
			KIND_OCT: radix = 8;
			KIND_HEXL, KIND_HEXU: radix = 16;
			default: radix = 10;
		endcase
		letter = (r.kind == KIND_HEXL) ? CH_LA : CH_UA;
		left   = r.pad[1];
		pad_ch = (r.pad == PAD_RZERO) ? CH_ZERO : CH_SPACE;
		w      = (r.width > MAX_WIDTH) ? MAX_WIDTH : r.width;
		neg    = (r.kind == KIND_SDEC) && r.value[VAL_W-1];
		mag    = neg ? (32'd0 - r.value) : r.value;
		len    = 0;
		do begin
			dg = mag % radix;
			mag = mag / radix;
			digs[len] = (dg > 9) ? CHAR_W'(letter + dg - 10) : CHAR_W'(CH_ZERO + dg);
			len++;
		end while (mag != 0 && len < MAX_DIGITS);
		if (neg) begin
			digs[len] = CH_MINUS;
			len++;
		end
		j = len;
		if (!left) begin
			while (j < w) begin
				line.push_back(pad_ch);
				j++;
			end
		end
		for (int i = len; i > 0; i--)
			line.push_back(digs[i-1]);
		while (j < w) begin
			line.push_back(CH_SPACE);
			j++;
		end
		foreach (line[k]) begin
			beat.ch   = line[k];
			beat.last = (k == line.size() - 1);
			pending_chars.push_back(beat);
		end
	endtask

	task automatic send_number(input fmt_req_t r);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, GAP_MAX) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {r.width, r.pad, r.value};
		s_axis_tuser  <= r.kind;
		do @(posedge clk); while (!s_axis_tready);
		format_number_text(r);
		items_sent++;
	endtask

	task automatic send_fields(input logic [VAL_W-1:0] value, input logic [KIND_W-1:0] kind,
			input logic [PAD_W-1:0] pad, input logic [WID_W-1:0] width);
		fmt_req_t r;
		r.value = value;
		r.kind  = kind;
		r.pad   = pad;
		r.width = width;
		send_number(r);
	endtask

	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	function automatic fmt_req_t random_request();
		fmt_req_t r;
		case ($urandom_range(0, 9)) inside
			[0:3]: r.value = $urandom;
			[4:5]: r.value = $urandom_range(0, 99);
			6: r.value = 32'h8000_0000 + $urandom_range(0, 3) - 2;
			7: r.value = 32'd0 - $urandom_range(1, 999);
			8: r.value = 32'd1 << $urandom_range(0, 31);
			default: r.value = 32'hFFFF_FFFF - $urandom_range(0, 15);
		endcase
		r.kind  = ($urandom_range(0, 9) < 9) ? KIND_W'($urandom_range(0, 5)) :
			KIND_W'($urandom_range(6, 7));
		r.pad   = PAD_W'($urandom_range(0, 3));
		r.width = ($urandom_range(0, 7) == 0) ? WID_W'($urandom_range(0, 63)) :
			WID_W'($urandom_range(0, 20));
		return r;
	endfunction

	task automatic test_digit_extremes();
		send_fields(32'h0000_0000, KIND_BIN,  PAD_RSPACE, 6'd0);
		send_fields(32'h0000_0000, KIND_HEXL, PAD_RZERO,  6'd5);
		send_fields(32'hFFFF_FFFF, KIND_BIN,  PAD_RSPACE, 6'd0);
		send_fields(32'hFFFF_FFFF, KIND_OCT,  PAD_RZERO,  6'd20);
		send_fields(32'hFFFF_FFFF, KIND_UDEC, PAD_LEFT,   6'd12);
		send_fields(32'hFFFF_FFFF, KIND_HEXU, PAD_RSPACE, 6'd63);
		send_fields(32'h8000_0000, KIND_SDEC, PAD_RSPACE, 6'd0);
		send_fields(32'hFFFF_FFFF, KIND_SDEC, PAD_RZERO,  6'd4);
		send_fields(32'h7FFF_FFFF, KIND_SDEC, PAD_LEFT,   6'd63);
		send_fields(32'h8000_0000, KIND_BIN,  PAD_LEFT,   6'd0);
		send_fields(32'h0000_FFFF, KIND_BIN,  PAD_LEFT_ALT, 6'd17);
	endtask

	task automatic test_conversion_kinds();
		logic [KIND_W-1:0] kinds [8];
		kinds = '{KIND_BIN, KIND_OCT, KIND_SDEC, KIND_UDEC,
			KIND_HEXL, KIND_HEXU, KIND_SPARE6, KIND_SPARE7};
		foreach (kinds[k])
			send_fields(32'hFFFF_CFC7, kinds[k], PAD_RSPACE, 6'd10);
	endtask

	task automatic test_padding_modes();
		send_fields(32'hFFFF_FFF4, KIND_SDEC, PAD_RZERO,    6'd6);
		send_fields(32'hFFFF_FFF4, KIND_SDEC, PAD_RSPACE,   6'd6);
		send_fields(32'hFFFF_FFF4, KIND_SDEC, PAD_LEFT_ALT, 6'd6);
		send_fields(32'h00AB_CDEF, KIND_HEXL, PAD_LEFT,     6'd8);
		send_fields(32'h00AB_CDEF, KIND_HEXU, PAD_RZERO,    6'd63);
	endtask

	task automatic test_drain_pause();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b1;
		repeat (4) send_number(random_request());
		wait_for_drain();
		send_fields(32'd42, KIND_UDEC, PAD_RZERO, 6'd3);
	endtask

	task automatic test_random_values();
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 40 == 0) begin
				tx_idle_en = 1'($urandom_range(0, 1));
				rx_idle_en = 1'($urandom_range(0, 1));
			end
			if (n == RAND_ITEMS / 2)
				wait_for_drain();
			send_number(random_request());
		end
	endtask

	// result checker, with random backpressure when rx_idle_en is set
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_chars.size() == 0) begin
					report_error($sformatf("unexpected character 0x%02h", m_axis_tdata));
				end else begin
					if (m_axis_tdata !== pending_chars[0].ch)
						report_error($sformatf("text_char got 0x%02h expected 0x%02h",
							m_axis_tdata, pending_chars[0].ch));
					if (m_axis_tlast !== pending_chars[0].last)
						report_error($sformatf("last_char got %b expected %b",
							m_axis_tlast, pending_chars[0].last));
					void'(pending_chars.pop_front());
				end
				chars_checked++;
				rx_gap = rx_idle_en ? $urandom_range(0, GAP_MAX) : 0;
				if (rx_gap == 0) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					rx_wait <= rx_gap;
				end
			end else if (rx_wait != 0) begin
				rx_wait <= rx_wait - 1;
				if (rx_wait == 1)
					m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_digit_extremes();
		test_conversion_kinds();
		test_padding_modes();
		test_drain_pause();
		test_random_values();
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("formatted %0d numbers over all conversion kinds, pad modes and widths",
			items_sent);
		$display("checked %0d characters under random source gaps and sink stalls",
			chars_checked);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/itf_pkg.sv
rtl/core/itf_digit.sv
rtl/core/integer_to_text_formatter.sv
rtl/core/itf_checker.sv
tb/tb_top.sv
